/* design/smnv_pkg.sv */
// Shared types and constants for the stack machine with named variables.
// No dependencies.
`default_nettype none
package smnv_pkg;
  localparam int STACK_DEPTH      = 128;
  localparam int VARIABLE_ENTRIES = 128;
  localparam int SP_W = $clog2(STACK_DEPTH);
  localparam int VI_W = $clog2(VARIABLE_ENTRIES);

  localparam logic [2:0] OP_PUSH  = 3'd0;
  localparam logic [2:0] OP_PUSHV = 3'd1;
  localparam logic [2:0] OP_ADD   = 3'd2;
  localparam logic [2:0] OP_DIV   = 3'd3;
  localparam logic [2:0] OP_MUL   = 3'd4;
  localparam logic [2:0] OP_SUB   = 3'd5;
  localparam logic [2:0] OP_PRINT = 3'd6;
  localparam logic [2:0] OP_POPV  = 3'd7;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNDERFLOW = 3'd1;
  localparam logic [2:0] ST_OVERFLOW  = 3'd2;
  localparam logic [2:0] ST_DIVZERO   = 3'd3;
  localparam logic [2:0] ST_UNKNOWN   = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] literal_value;
    logic [63:0]        variable_key;
  } in_item_t;

  typedef struct packed {
    logic               print_valid;
    logic signed [31:0] print_value;
    logic [2:0]         status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RDA, S_RDB, S_OPS, S_DIV, S_SRCH, S_SRCHW, S_DONE, S_OUT
  } state_t;
endpackage
`default_nettype wire

/* design/stack_machine_with_named_variables_core.sv */
// Top level of the stack machine with named variables.
// Depends on smnv_pkg.
`default_nettype none
// Usage:
//  in_* channel carries one instruction item (opcode, literal, key).
//  out_* channel returns exactly one result item per instruction.
//  An item moves when valid is high and stall is low.
//  The operand stack and the variable table live in synchronous RAMs
//  with registered reads; the block works on one item at a time.
//  Divide produces one quotient bit per cycle. Push variable and pop
//  variable walk the table entry by entry, up to the table fill, with
//  an address step and then a registered read for each entry.
//  The block returns to idle after each result before it takes the
//  next item.
//  The result waits in an output register; a new item is taken only
//  after the result has left. When out_stall is high the result holds.
//  Reset clears the state, the output valid and the stack and table counts;
//  RAM contents are not cleared since entries above the counts are never read.
module stack_machine_with_named_variables_core
  import smnv_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);
  logic [31:0] stk_mem [STACK_DEPTH];
  logic [63:0] key_mem [VARIABLE_ENTRIES];
  logic [31:0] val_mem [VARIABLE_ENTRIES];

  state_t state_r, state_nxt;
  in_item_t   item_r;
  logic [7:0] sc_r, sc_nxt;
  logic [7:0] vc_r, vc_nxt;
  logic [31:0] a_r, a_nxt;
  logic [7:0] idx_r, idx_nxt;
  logic [5:0] dcnt_r, dcnt_nxt;
  logic [31:0] q_r, q_nxt, rem_r, rem_nxt, den_r, den_nxt;
  logic        neg_r, neg_nxt;
  out_item_t  res_r, res_nxt;
  logic        ov_r, ov_nxt;

  // RAM ports
  logic        s_we;
  logic [SP_W-1:0] s_wa, s_ra;
  logic [31:0] s_wd, s_rd;
  logic        v_we, k_we;
  logic [VI_W-1:0] v_wa, v_ra;
  logic [31:0] v_wd, v_rd;
  logic [63:0] k_rd;

  always_ff @(posedge clk) begin
    if (s_we) stk_mem[s_wa] <= s_wd;
    s_rd <= stk_mem[s_ra];
    if (v_we) val_mem[v_wa] <= v_wd;
    if (k_we) key_mem[v_wa] <= item_r.variable_key;
    v_rd <= val_mem[v_ra];
    k_rd <= key_mem[v_ra];
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = res_r;

  logic [32:0] trial;
  assign trial = {rem_r, q_r[31]} - {1'b0, den_r};

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_RDA;
      S_RDA: begin
        case (item_r.opcode)
          OP_PUSH: state_nxt = S_DONE;
          OP_PUSHV: state_nxt = (sc_r >= 8'(STACK_DEPTH)) ? S_DONE : S_SRCH;
          OP_PRINT: state_nxt = (sc_r == 8'd0) ? S_DONE : S_RDB;
          OP_POPV: state_nxt = (sc_r == 8'd0) ? S_DONE : S_RDB;
          default: state_nxt = (sc_r < 8'd2) ? S_DONE : S_RDB;
        endcase
      end
      S_RDB: begin
        if (item_r.opcode == OP_PRINT) state_nxt = S_DONE;
        else if (item_r.opcode == OP_POPV) state_nxt = S_SRCH;
        else state_nxt = S_OPS;
      end
      S_OPS: state_nxt = (item_r.opcode == OP_DIV && s_rd != 32'd0) ? S_DIV : S_DONE;
      S_DIV: if (dcnt_r == 6'd31) state_nxt = S_DONE;
      S_SRCH: state_nxt = (idx_r >= vc_r) ? S_DONE : S_SRCHW;
      S_SRCHW: state_nxt = (k_rd == item_r.variable_key) ? S_DONE : S_SRCH;
      S_DONE: state_nxt = S_OUT;
      S_OUT: if (!ov_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    sc_nxt = sc_r; vc_nxt = vc_r; a_nxt = a_r;
    idx_nxt = idx_r; dcnt_nxt = dcnt_r; q_nxt = q_r; rem_nxt = rem_r;
    den_nxt = den_r; neg_nxt = neg_r; res_nxt = res_r; ov_nxt = ov_r;
    s_we = 1'b0; s_wa = sc_r[SP_W-1:0]; s_wd = 32'd0;
    s_ra = SP_W'(sc_r - 8'd1);
    v_we = 1'b0; k_we = 1'b0; v_wa = idx_r[VI_W-1:0]; v_wd = a_r;
    v_ra = idx_r[VI_W-1:0];
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        res_nxt = '0;
        idx_nxt = 8'd0;
        s_ra = SP_W'(sc_r - 8'd1);
      end
      S_RDA: begin
        case (item_r.opcode)
          OP_PUSH: begin
            if (sc_r >= 8'(STACK_DEPTH)) res_nxt.status = ST_OVERFLOW;
            else begin
              s_we = 1'b1; s_wd = item_r.literal_value; sc_nxt = sc_r + 8'd1;
            end
          end
          OP_PUSHV: if (sc_r >= 8'(STACK_DEPTH)) res_nxt.status = ST_OVERFLOW;
          OP_PRINT, OP_POPV: if (sc_r == 8'd0) res_nxt.status = ST_UNDERFLOW;
          default: if (sc_r < 8'd2) res_nxt.status = ST_UNDERFLOW;
        endcase
      end
      S_RDB: begin
        a_nxt = s_rd;
        s_ra = SP_W'(sc_r - 8'd2);
        if (item_r.opcode == OP_PRINT) begin
          res_nxt.print_valid = 1'b1; res_nxt.print_value = s_rd;
          sc_nxt = sc_r - 8'd1;
        end
      end
      S_OPS: begin
        s_wa = SP_W'(sc_r - 8'd2);
        neg_nxt = a_r[31] ^ s_rd[31];
        q_nxt = a_r[31] ? (32'd0 - a_r) : a_r;
        den_nxt = s_rd[31] ? (32'd0 - s_rd) : s_rd;
        rem_nxt = 32'd0; dcnt_nxt = 6'd0;
        case (item_r.opcode)
          OP_ADD: begin s_we = 1'b1; s_wd = a_r + s_rd; sc_nxt = sc_r - 8'd1; end
          OP_SUB: begin s_we = 1'b1; s_wd = a_r - s_rd; sc_nxt = sc_r - 8'd1; end
          OP_MUL: begin s_we = 1'b1; s_wd = a_r * s_rd; sc_nxt = sc_r - 8'd1; end
          default: begin
            if (s_rd == 32'd0) begin
              s_we = 1'b1; s_wd = 32'd0; sc_nxt = sc_r - 8'd1;
              res_nxt.status = ST_DIVZERO;
            end
          end
        endcase
      end
      S_DIV: begin
        // one restoring quotient bit per cycle
        if (!trial[32]) begin
          rem_nxt = trial[31:0]; q_nxt = {q_r[30:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[30:0], q_r[31]}; q_nxt = {q_r[30:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 6'd1;
        if (dcnt_r == 6'd31) begin
          s_we = 1'b1; s_wa = SP_W'(sc_r - 8'd2);
          s_wd = neg_r ? (32'd0 - q_nxt) : q_nxt;
          sc_nxt = sc_r - 8'd1;
        end
      end
      S_SRCH: begin
        if (idx_r >= vc_r) begin
          if (item_r.opcode == OP_PUSHV) begin
            res_nxt.status = ST_UNKNOWN;
            s_we = 1'b1; s_wd = 32'd0; sc_nxt = sc_r + 8'd1;
          end else if (vc_r >= 8'(VARIABLE_ENTRIES)) begin
            res_nxt.status = ST_FULL;
          end else begin
            v_we = 1'b1; k_we = 1'b1; v_wa = vc_r[VI_W-1:0];
            vc_nxt = vc_r + 8'd1; sc_nxt = sc_r - 8'd1;
          end
        end
      end
      S_SRCHW: begin
        if (k_rd == item_r.variable_key) begin
          if (item_r.opcode == OP_PUSHV) begin
            s_we = 1'b1; s_wd = v_rd; sc_nxt = sc_r + 8'd1;
          end else begin
            v_we = 1'b1; sc_nxt = sc_r - 8'd1;
          end
        end else idx_nxt = idx_r + 8'd1;
      end
      S_DONE: ov_nxt = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; sc_r <= 8'd0; vc_r <= 8'd0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; sc_r <= sc_nxt; vc_r <= vc_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) item_r <= in_data;
    a_r <= a_nxt; idx_r <= idx_nxt; dcnt_r <= dcnt_nxt;
    q_r <= q_nxt; rem_r <= rem_nxt; den_r <= den_nxt; neg_r <= neg_nxt;
    res_r <= res_nxt;
  end
endmodule
`default_nettype wire
